### sv/lss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared widths, constants, types and the neighbor selection function of the
// 3x3 label spreading block.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int LABEL_W     = 8;
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  // The row counter runs through two drain rows past the last image row.
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(480);

  localparam logic [LABEL_W-1:0] LABEL_FREE     = 8'd255;
  localparam logic [LABEL_W-1:0] LABEL_OBSTACLE = 8'd0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Window indexed [row][col]; row 0 is the upper row, col 2 the newest.
  typedef logic [2:0][2:0][LABEL_W-1:0] win_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               last;
  } res_t;

  // A free center takes the last qualifying neighbor in raster order.
  function automatic logic [LABEL_W-1:0] spread(input win_t w);
    logic [LABEL_W-1:0] result;
    result = w[1][1];
    if (result == LABEL_FREE) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (w[r][c] != LABEL_OBSTACLE && w[r][c] != LABEL_FREE) begin
            result = w[r][c];
          end
        end
      end
    end
    return result;
  endfunction

endpackage
`default_nettype wire

### sv/lss_pixel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pixel_if
// Input channel of the label spreading block: one pixel or drain tick a word.
// ----------------------------------------------------------------------------
interface lss_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lss_pkg::LABEL_W-1:0] label_in;
  logic                        flush;

  modport source (output valid, output label_in, output flush, input ready);
  modport sink   (input valid, input label_in, input flush, output ready);
endinterface
`default_nettype wire

### sv/lss_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_result_if
// Output channel of the label spreading block: one result pixel a word.
// ----------------------------------------------------------------------------
interface lss_result_if;
  logic                        valid;
  logic                        ready;
  logic [lss_pkg::LABEL_W-1:0] label_out;
  logic                        frame_last;

  modport source (output valid, output label_out, output frame_last, input ready);
  modport sink   (input valid, input label_out, input frame_last, output ready);
endinterface
`default_nettype wire

### sv/lss_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lss_pkg::CFG_INDEX_W-1:0] index;
  logic [lss_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/lss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### sv/lss_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_result_fifo
// Small result queue that decouples the output handshake from the pipeline.
// ----------------------------------------------------------------------------
module lss_result_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic                             push,
  input  lss_pkg::res_t                    push_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output lss_pkg::res_t                    out_data,
  output logic [lss_pkg::FIFO_CNT_W-1:0]   count
);

  lss_pkg::res_t                   entries [lss_pkg::FIFO_DEPTH];
  logic [lss_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [lss_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic                            pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lss_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lss_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + lss_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - lss_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### sv/label_spread_3x3_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// label_spread_3x3_stencil
// One pass of 3x3 label spreading over a raster-order 8-bit label map.
// ----------------------------------------------------------------------------
// The block takes one word per clock on the pixel channel while ready is high
// and gives at most one result word per clock; a frame of W x H pixels is
// followed by its W+1 drain words. Each result trails its input by one row
// plus one pixel of input words; the result that a word causes goes through
// the stage register b and then the result queue. The two previous rows
// live in one 16-bit wide RAM of MAX_WIDTH entries, one entry per column that
// holds the labels two rows back and one row back. A column is read when its
// word is taken and written back in the next cycle, and a one-entry bypass
// covers the case where the next word reads the same column (a one-pixel-wide
// image). The RAM needs no clearing after reset, because a row is only read
// once it has been written in the frame. Results go through a four-word queue;
// ready drops only while that queue and the word in flight already hold three
// words or more. Configuration writes are taken at any time (ready is held
// high) but must only come while the block is idle; any write, also to an
// unused index, restarts the frame.
// ----------------------------------------------------------------------------
module label_spread_3x3_stencil (
  input  logic          clk,
  input  logic          rst,
  lss_pixel_if.sink     pixel,
  lss_result_if.source  result,
  lss_cfg_if.sink       cfg
);

  // Second pipeline stage: one word whose RAM read is returning.
  typedef struct packed {
    logic                           first_col;
    logic                           r1;
    logic                           r2;
    logic                           last;
    logic [lss_pkg::LABEL_W-1:0]    value;
    logic [lss_pkg::COL_W-1:0]      addr;
    logic                           fwd;
    logic [2*lss_pkg::LABEL_W-1:0]  fwd_data;
  } stage_t;

  // Configuration registers and their saturated working values.
  logic [lss_pkg::CFG_DATA_W-1:0] image_width;
  logic [lss_pkg::CFG_DATA_W-1:0] image_height;
  logic [lss_pkg::CFG_DATA_W-1:0] eff_w;
  logic [lss_pkg::CFG_DATA_W-1:0] eff_h;

  // Input position.
  logic [lss_pkg::COL_W-1:0] col;
  logic [lss_pkg::ROW_W-1:0] row;

  // Stage registers and the 3x3 window.
  logic          b_valid;
  stage_t        b;
  stage_t        a_stage;
  lss_pkg::win_t win;
  lss_pkg::win_t win_next;
  lss_pkg::win_t win_edge;

  // First stage decode.
  logic                     cfg_write;
  logic                     in_take;
  logic                     in_frame;
  logic                     step;
  logic                     first_col;
  logic                     is_last;
  logic [lss_pkg::COL_W:0]  col_inc;
  logic                     wrap;

  // Second stage datapath.
  logic [2*lss_pkg::LABEL_W-1:0] ram_rdata;
  logic [2*lss_pkg::LABEL_W-1:0] row_data;
  logic [2*lss_pkg::LABEL_W-1:0] ram_wdata;
  logic [lss_pkg::LABEL_W-1:0]   top_v;
  logic [lss_pkg::LABEL_W-1:0]   mid_v;

  // Result queue.
  logic                           fifo_push;
  lss_pkg::res_t                  fifo_in;
  lss_pkg::res_t                  fifo_out;
  logic                           fifo_valid;
  logic [lss_pkg::FIFO_CNT_W-1:0] fifo_count;

  // Out-of-range register values saturate into the legal range.
  always_comb begin
    if (image_width == '0) begin
      eff_w = lss_pkg::CFG_DATA_W'(1);
    end else if (image_width > lss_pkg::CFG_DATA_W'(lss_pkg::MAX_WIDTH)) begin
      eff_w = lss_pkg::CFG_DATA_W'(lss_pkg::MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = lss_pkg::CFG_DATA_W'(1);
    end else if (image_height > lss_pkg::CFG_DATA_W'(lss_pkg::MAX_HEIGHT)) begin
      eff_h = lss_pkg::CFG_DATA_W'(lss_pkg::MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid & cfg.ready;

  // The queue must be able to absorb the word in flight and the one taken now.
  assign pixel.ready = ((lss_pkg::FIFO_CNT_W+1)'(fifo_count)
                        + (lss_pkg::FIFO_CNT_W+1)'(b_valid))
                       <= (lss_pkg::FIFO_CNT_W+1)'(lss_pkg::FIFO_DEPTH - 2);
  assign in_take = pixel.valid & pixel.ready;

  // A flush word that arrives while image rows are still due is dropped.
  // Past the last image row every word is a drain tick.
  assign in_frame  = (row < lss_pkg::ROW_W'(eff_h));
  assign step      = in_take & ~(in_frame & pixel.flush);
  assign first_col = (col == '0);
  assign is_last   = first_col
                     && (row == lss_pkg::ROW_W'(eff_h) + lss_pkg::ROW_W'(1));
  assign col_inc   = {1'b0, col} + (lss_pkg::COL_W+1)'(1);
  assign wrap      = (col_inc == (lss_pkg::COL_W+1)'(eff_w));

  always_comb begin
    a_stage.first_col = first_col;
    a_stage.r1        = (row != '0);
    a_stage.r2        = (row >= lss_pkg::ROW_W'(2));
    a_stage.last      = is_last;
    a_stage.value     = in_frame ? pixel.label_in : lss_pkg::LABEL_OBSTACLE;
    a_stage.addr      = col;
    // The word ahead writes this column back in the same cycle as our read.
    a_stage.fwd       = b_valid && (b.addr == col);
    a_stage.fwd_data  = ram_wdata;
  end

  lss_ram #(
    .WIDTH (2*lss_pkg::LABEL_W),
    .DEPTH (lss_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (b_valid),
    .wr_addr (b.addr),
    .wr_data (ram_wdata),
    .rd_en   (step),
    .rd_addr (col),
    .rd_data (ram_rdata)
  );

  // Second stage: rows above come from the RAM (or the bypass), rows not yet
  // written in this frame read as obstacles.
  always_comb begin
    row_data  = b.fwd ? b.fwd_data : ram_rdata;
    top_v     = b.r2 ? row_data[2*lss_pkg::LABEL_W-1:lss_pkg::LABEL_W]
                     : lss_pkg::LABEL_OBSTACLE;
    mid_v     = b.r1 ? row_data[lss_pkg::LABEL_W-1:0] : lss_pkg::LABEL_OBSTACLE;
    ram_wdata = {mid_v, b.value};

    // At the start of a row the window still holds the end of the previous
    // row; its right column lies outside the image.
    for (int k = 0; k < 3; k++) begin
      win_edge[k][0] = win[k][1];
      win_edge[k][1] = win[k][2];
      win_edge[k][2] = lss_pkg::LABEL_OBSTACLE;
      win_next[k][0] = b.first_col ? lss_pkg::LABEL_OBSTACLE : win[k][1];
      win_next[k][1] = b.first_col ? lss_pkg::LABEL_OBSTACLE : win[k][2];
    end
    win_next[0][2] = top_v;
    win_next[1][2] = mid_v;
    win_next[2][2] = b.value;

    fifo_push     = b_valid & (b.first_col ? b.r2 : b.r1);
    fifo_in.label = b.first_col ? lss_pkg::spread(win_edge)
                                : lss_pkg::spread(win_next);
    fifo_in.last  = b.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lss_pkg::WIDTH_RESET;
      image_height <= lss_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      b_valid      <= 1'b0;
      win          <= '0;
    end else if (cfg_write) begin
      case (cfg.index)
        lss_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg.data;
        end
        lss_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data;
        end
        default: begin
        end
      endcase
      col     <= '0;
      row     <= '0;
      b_valid <= 1'b0;
      win     <= '0;
    end else begin
      b_valid <= step;
      if (step) begin
        if (is_last) begin
          col <= '0;
          row <= '0;
        end else if (wrap) begin
          col <= '0;
          row <= row + lss_pkg::ROW_W'(1);
        end else begin
          col <= col_inc[lss_pkg::COL_W-1:0];
        end
      end
      if (b_valid) begin
        win <= b.last ? '0 : win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b <= a_stage;
    end
  end

  lss_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_write),
    .push      (fifo_push),
    .push_data (fifo_in),
    .out_ready (result.ready),
    .out_valid (fifo_valid),
    .out_data  (fifo_out),
    .count     (fifo_count)
  );

  assign result.valid      = fifo_valid;
  assign result.label_out  = fifo_out.label;
  assign result.frame_last = fifo_out.last;

  // The input column always lies inside the configured row.
  ap_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col} < (lss_pkg::COL_W+1)'(eff_w)))
    else $error("column position outside the image width");

  // The ready rule keeps the queue from ever being pushed while full.
  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (fifo_count < lss_pkg::FIFO_CNT_W'(lss_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  // The closing drain word of a frame always yields the frame's last pixel.
  ap_last_emits: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b.last) |-> fifo_push)
    else $error("frame end without a result");

  // The bypass only feeds real row data when the image is one pixel wide.
  ap_fwd_narrow: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b.fwd && b.r1) |-> (eff_w == lss_pkg::CFG_DATA_W'(1)))
    else $error("same-column bypass on a wide image");

  // Input stalls only while results are backed up.
  ap_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (fifo_count >= lss_pkg::FIFO_CNT_W'(2)))
    else $error("input stalled without a result backlog");

endmodule
`default_nettype wire

### tb/sv/tb_label_spread_3x3_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_label_spread_3x3_stencil
// Self-checking testbench for the 3x3 label spreading block.
// ----------------------------------------------------------------------------
// Pixel words are driven on the input channel with random gaps. Each word is
// passed through a cycle-free model of the spreading pass at the moment the
// block takes it, and any result that word causes is queued. A receiver with
// random stalls compares every result word, field by field, with the oldest
// queued one. The run covers a short hand-made frame with an early flush and a
// pixel word during the drain, register saturation, mid-frame restarts, the
// largest width and height in frames cut short, and then a stream of random
// frames.
// ----------------------------------------------------------------------------
module tb_label_spread_3x3_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500_000;
  // Extra wait after the last owed result, so that the block is idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 900;
  localparam int EXTREME_WORDS = 240;
  localparam logic [lss_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

  logic clk = 1'b0;
  logic rst;

  lss_pixel_if  pix_if ();
  lss_result_if res_if ();
  lss_cfg_if    cfg_if ();

  label_spread_3x3_stencil DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bookkeeping.
  // --------------------------------------------------------------------------
  lss_pkg::res_t pending_labels [$];  // spread labels still owed by the block
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   words_sent   = 0;    // counted pixel and drain words
  bit            no_gaps      = 1'b0; // both sides run without idling when set

  // --------------------------------------------------------------------------
  // Spreading model. It keeps its own copy of the geometry registers, the two
  // previous rows, the 3x3 window and the scan position.
  // --------------------------------------------------------------------------
  logic [lss_pkg::CFG_DATA_W-1:0] geom_width;
  logic [lss_pkg::CFG_DATA_W-1:0] geom_height;
  logic [lss_pkg::LABEL_W-1:0]    row_two_back [lss_pkg::MAX_WIDTH];
  logic [lss_pkg::LABEL_W-1:0]    row_one_back [lss_pkg::MAX_WIDTH];
  lss_pkg::win_t                  stencil;
  int unsigned                    scan_col;
  int unsigned                    scan_row;

  // A register value of zero acts as one, anything past the limit as the limit.
  function automatic int unsigned clamp_dim(
      input logic [lss_pkg::CFG_DATA_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_width();
    return clamp_dim(geom_width, lss_pkg::MAX_WIDTH);
  endfunction

  function automatic int unsigned frame_height();
    return clamp_dim(geom_height, lss_pkg::MAX_HEIGHT);
  endfunction

  function automatic void restart_scan();
    stencil  = '0;
    scan_col = 0;
    scan_row = 0;
  endfunction

  // The last qualifying neighbor in raster order is the first one met when
  // the window is walked backwards from its lower right corner.
  function automatic logic [lss_pkg::LABEL_W-1:0] spread_label(
      input lss_pkg::win_t w);
    logic [lss_pkg::LABEL_W-1:0] v;
    if (w[1][1] != lss_pkg::LABEL_FREE) return w[1][1];
    for (int i = 8; i >= 0; i--) begin
      v = w[i / 3][i % 3];
      if (v != lss_pkg::LABEL_OBSTACLE && v != lss_pkg::LABEL_FREE) return v;
    end
    return lss_pkg::LABEL_FREE;
  endfunction

  function automatic void apply_register(
      input logic [lss_pkg::CFG_INDEX_W-1:0] idx,
      input logic [lss_pkg::CFG_DATA_W-1:0] data);
    if (idx == lss_pkg::REG_IMAGE_WIDTH) begin
      geom_width = data;
    end else if (idx == lss_pkg::REG_IMAGE_HEIGHT) begin
      geom_height = data;
    end
    // Any write, also to an unused index, starts the frame over.
    restart_scan();
  endfunction

  // Advances the model by one taken pixel word and queues the result it causes.
  function automatic void predict_word(input logic [lss_pkg::LABEL_W-1:0] label,
                                       input logic flush);
    int unsigned                 w;
    int unsigned                 h;
    int unsigned                 c;
    int unsigned                 r;
    logic [lss_pkg::LABEL_W-1:0] incoming;
    logic [lss_pkg::LABEL_W-1:0] above;
    logic [lss_pkg::LABEL_W-1:0] beside;
    lss_pkg::win_t               shifted;
    lss_pkg::res_t               res;
    bit                          emitted;
    w       = frame_width();
    h       = frame_height();
    c       = scan_col;
    r       = scan_row;
    emitted = 1'b0;
    res     = '0;
    // A flush before the last pixel of the frame changes nothing.
    if (r < h && flush) return;
    if (c >= w) begin
      restart_scan();
      c = 0;
      r = 0;
    end
    // During the drain rows the label is thrown away.
    incoming = (r < h) ? label : lss_pkg::LABEL_OBSTACLE;
    above    = (r >= 2) ? row_two_back[c] : lss_pkg::LABEL_OBSTACLE;
    beside   = (r >= 1) ? row_one_back[c] : lss_pkg::LABEL_OBSTACLE;
    if (c == 0) begin
      // The pixel at the right end of the previous row is finished now, with
      // the column past the image edge counted as obstacle.
      if (r >= 2) begin
        for (int k = 0; k < 3; k++) begin
          shifted[k][0] = stencil[k][1];
          shifted[k][1] = stencil[k][2];
          shifted[k][2] = lss_pkg::LABEL_OBSTACLE;
        end
        res.label = spread_label(shifted);
        res.last  = (r == h + 1);
        emitted   = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        stencil[k][0] = lss_pkg::LABEL_OBSTACLE;
        stencil[k][1] = lss_pkg::LABEL_OBSTACLE;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        stencil[k][0] = stencil[k][1];
        stencil[k][1] = stencil[k][2];
      end
    end
    stencil[0][2] = above;
    stencil[1][2] = beside;
    stencil[2][2] = incoming;
    if (c != 0 && r >= 1) begin
      res.label = spread_label(stencil);
      res.last  = 1'b0;
      emitted   = 1'b1;
    end
    row_two_back[c] = beside;
    row_one_back[c] = incoming;
    if (emitted && res.last) begin
      restart_scan();
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      scan_col = c;
      scan_row = r;
    end
    if (emitted) pending_labels = {pending_labels, res};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Labels lean toward the free and obstacle codes and a handful of room
  // labels, so that spreading and overwriting by later neighbors happen often.
  function automatic logic [lss_pkg::LABEL_W-1:0] rand_label();
    case ($urandom_range(0, 9))
      0, 1, 2: return lss_pkg::LABEL_FREE;
      3, 4:    return lss_pkg::LABEL_OBSTACLE;
      5, 6, 7: return lss_pkg::LABEL_W'($urandom_range(1, 6));
      default: return lss_pkg::LABEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one pixel word. Valid stays high into the next word when no gap is
  // drawn, so the block can take a word every cycle.
  task automatic send_word(input logic [lss_pkg::LABEL_W-1:0] label,
                           input logic flush);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk);
    pix_if.valid    <= 1'b1;
    pix_if.label_in <= label;
    pix_if.flush    <= flush;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_word(label, flush);
  endtask

  // Parks the input and waits until every owed result has come back, then
  // lets the block settle so that a register write finds it idle.
  task automatic wait_idle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [lss_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [lss_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [lss_pkg::CFG_DATA_W-1:0] w,
                              input logic [lss_pkg::CFG_DATA_W-1:0] h);
    wait_idle();
    write_register(lss_pkg::REG_IMAGE_WIDTH, w);
    write_register(lss_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) begin
      send_word(rand_label(), 1'b0);
      words_sent++;
    end
  endtask

  // One full frame and its drain. In a noisy frame some early flush words are
  // mixed into the pixels (the block drops them), and some drain words come
  // without the flush bit.
  task automatic send_frame(input bit noisy);
    int unsigned n;
    n = frame_width() * frame_height();
    repeat (n) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        send_word(lss_pkg::LABEL_W'($urandom_range(0, 255)), 1'b1);
      end
      send_word(rand_label(), 1'b0);
      words_sent++;
    end
    repeat (frame_width() + 1) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        send_word(lss_pkg::LABEL_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_word(lss_pkg::LABEL_W'($urandom_range(0, 255)), 1'b1);
      end
      words_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, then every taken result word is checked
  // against the oldest owed label.
  // --------------------------------------------------------------------------
  initial begin
    int            stall;
    lss_pkg::res_t owed;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      if (pending_labels.size() == 0) begin
        report_mismatch($sformatf("result word label=%0d last=%0b with none owed",
                                  res_if.label_out, res_if.frame_last));
      end else begin
        owed = pending_labels.pop_front();
        if (res_if.label_out !== owed.label) begin
          report_mismatch($sformatf("label_out=%0d, owed %0d",
                                    res_if.label_out, owed.label));
        end
        if (res_if.frame_last !== owed.last) begin
          report_mismatch($sformatf("frame_last=%0b, owed %0b",
                                    res_if.frame_last, owed.last));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** label_spread_3x3_stencil: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // A 3x3 frame by hand: a free center that must pick the last room label
  // around it, border pixels whose outer neighbors count as obstacle, an early
  // flush that must be dropped, and a pixel word in the drain whose label must
  // be ignored.
  task automatic test_hand_frame();
    logic [lss_pkg::LABEL_W-1:0] pattern [9];
    pattern = '{lss_pkg::LABEL_FREE, 8'd7, lss_pkg::LABEL_OBSTACLE,
                8'd254, lss_pkg::LABEL_FREE, lss_pkg::LABEL_FREE,
                lss_pkg::LABEL_FREE, lss_pkg::LABEL_OBSTACLE, 8'd1};
    set_geometry(lss_pkg::CFG_DATA_W'(3), lss_pkg::CFG_DATA_W'(3));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(8'hA5, 1'b1);
      send_word(pattern[i], 1'b0);
    end
    send_word(lss_pkg::LABEL_OBSTACLE, 1'b1);
    send_word(8'hAA, 1'b0);
    send_word(lss_pkg::LABEL_FREE, 1'b1);
    send_word(lss_pkg::LABEL_OBSTACLE, 1'b1);
  endtask

  // Zero in both registers acts as a one-pixel image, where every neighbor
  // lies outside and a free pixel must stay free.
  task automatic test_zero_geometry();
    set_geometry('0, '0);
    send_word(lss_pkg::LABEL_FREE, 1'b0);
    send_word(lss_pkg::LABEL_OBSTACLE, 1'b1);
    send_word(lss_pkg::LABEL_FREE, 1'b1);
  endtask

  // A write to an unused index in the middle of a frame starts the frame
  // over without touching the geometry.
  task automatic test_restart_midframe();
    set_geometry(lss_pkg::CFG_DATA_W'(2), lss_pkg::CFG_DATA_W'(2));
    send_pixels(3);
    wait_idle();
    write_register(REG_UNUSED_TOP, '1);
    send_frame(1'b0);
  endtask

  // The widest and the tallest geometry, both reached through saturation of
  // an all-ones register value. Each frame is cut short after a few hundred
  // words by the next geometry write, and a small geometry is left behind.
  task automatic test_extreme_geometry();
    set_geometry('1, '1);
    send_pixels(EXTREME_WORDS);
    set_geometry(lss_pkg::CFG_DATA_W'(1), '1);
    send_pixels(EXTREME_WORDS);
    set_geometry(lss_pkg::CFG_DATA_W'(4), lss_pkg::CFG_DATA_W'(4));
  endtask

  // Mostly well-formed frames of random size and content, with some frames
  // cut short by a restart and noise words inside the others.
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned cut;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 0) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        // A size of one is also reachable by writing zero.
        if (w == 1 && $urandom_range(0, 1) == 1) w = 0;
        if (h == 1 && $urandom_range(0, 1) == 1) h = 0;
        set_geometry(lss_pkg::CFG_DATA_W'(w), lss_pkg::CFG_DATA_W'(h));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, frame_width() * frame_height());
        send_pixels(cut);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          write_register(lss_pkg::CFG_INDEX_W'($urandom_range(
                           lss_pkg::REG_IMAGE_HEIGHT + 1, REG_UNUSED_TOP)),
                         lss_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
        end else begin
          write_register(lss_pkg::REG_IMAGE_WIDTH, geom_width);
        end
      end
      send_frame(1'b1);
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    pix_if.valid    = 1'b0;
    pix_if.label_in = '0;
    pix_if.flush    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    rst             = 1'b1;
    geom_width      = lss_pkg::WIDTH_RESET;
    geom_height     = lss_pkg::HEIGHT_RESET;
    restart_scan();
    for (int i = 0; i < lss_pkg::MAX_WIDTH; i++) begin
      row_two_back[i] = '0;
      row_one_back[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_hand_frame();
    test_zero_geometry();
    test_restart_midframe();
    test_extreme_geometry();
    test_random_frames();

    // Drain everything still owed, then give late stray words time to show.
    wait_idle();
    if (error_count == 0) begin
      $display("** label_spread_3x3_stencil: PASSED **");
    end else begin
      $display("** label_spread_3x3_stencil: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/lss_pkg.sv
sv/lss_pixel_if.sv
sv/lss_result_if.sv
sv/lss_cfg_if.sv
sv/lss_ram.sv
sv/lss_result_fifo.sv
sv/label_spread_3x3_stencil.sv
tb/sv/tb_label_spread_3x3_stencil.sv
